[sv/bkt_pkg.sv]
// ----------------------------------------------------------------------------
// bkt_pkg: shared types and constants for the bakery ticket lock arbiter
// Holds the slot and ticket sizes, status codes, channel payloads and the
// ticket-file write request.
// ----------------------------------------------------------------------------
package bkt_pkg;

  localparam int MAX_REQUESTERS = 16;
  localparam int TICKET_W       = 16;
  localparam int IDX_W          = 4;   // width of the requester field
  localparam int CFG_W          = 5;   // width of active_requesters
  localparam int SLOT_W         = $clog2(MAX_REQUESTERS);

  localparam logic [TICKET_W-1:0] TICKET_MAX = '1;
  localparam logic [CFG_W-1:0]    CFG_RESET  = CFG_W'(MAX_REQUESTERS);

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_INDEX  = 3'd1,
    ST_DOUBLE_ENT = 3'd2,
    ST_NO_TICKET  = 3'd3,
    ST_SATURATED  = 3'd4
  } status_t;

  typedef enum logic {
    CMD_ENTER = 1'b0,
    CMD_LEAVE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] requester;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    holder;
    logic                holder_valid;
    logic [TICKET_W-1:0] issued_ticket;
    logic [2:0]          status;
  } out_item_t;

  // write request into the ticket file
  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   addr;
    logic [TICKET_W-1:0] data;
  } tkt_wr_t;

endpackage

[sv/bkt_ticket_file.sv]
// ----------------------------------------------------------------------------
// bkt_ticket_file: per-requester ticket storage
// One ticket register per slot, cleared at reset, one read port selected by
// the scan index and one write port.
// ----------------------------------------------------------------------------
module bkt_ticket_file
  import bkt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SLOT_W-1:0]   rd_idx,
  output logic [TICKET_W-1:0] rd_data,
  input  tkt_wr_t             wr
);

  logic [TICKET_W-1:0] tickets_r [MAX_REQUESTERS];

  // clear on reset, write one slot per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_REQUESTERS; i++) begin
        tickets_r[i] <= '0;
      end
    end else if (wr.en) begin
      tickets_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = tickets_r[rd_idx];

endmodule

[sv/bakery_ticket_lock_arbiter_unit.sv]
// ----------------------------------------------------------------------------
// bakery_ticket_lock_arbiter_unit: bakery-rule lock arbiter
// Issues tickets on enter, clears them on leave and reports the holder with
// the smallest nonzero ticket, ties to the lower index.
//
//   channel | direction | payload          | handshake
//   in_     | input     | in_item_t        | in_valid / in_ready
//   out_    | output    | out_item_t       | out_valid / out_ready
//   cfg_    | input     | active_requesters| cfg_valid / cfg_ready
//
// After its transfer an item scans the first N slots, N being the clamped slot
// count, one slot per cycle through the shared scan compare, then a decide
// step writes the ticket and loads the result.
// in_ready is high only while the sequencer is idle; a stalled result holds
// the decide step until it is taken. Reset clears all tickets and sets the
// slot count to 16; cfg_ready is always high.
// ----------------------------------------------------------------------------
module bakery_ticket_lock_arbiter_unit
  import bkt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    cfg_r;
  logic [SLOT_W-1:0]   last_r;      // clamped slot count minus one
  logic [SLOT_W-1:0]   last_nxt;
  logic [SLOT_W-1:0]   k_r;
  logic                cmd_r;
  logic [IDX_W-1:0]    who_r;
  logic [TICKET_W-1:0] top_r, own_r, best_t_r;
  logic [SLOT_W-1:0]   best_idx_r;
  logic                found_r;
  logic                out_valid_r;
  out_item_t           out_r;

  logic [TICKET_W-1:0] rd_data;
  tkt_wr_t             wr;
  logic                in_xfer, out_free, in_range, is_self;
  status_t             status;
  logic [TICKET_W-1:0] new_tw, issued;
  logic                take_w;

  bkt_ticket_file u_tickets (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (k_r),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  // clamp the slot count to 1..MAX_REQUESTERS
  always_comb begin
    if (cfg_r == '0) begin
      last_nxt = '0;
    end else if (cfg_r > CFG_W'(MAX_REQUESTERS)) begin
      last_nxt = SLOT_W'(MAX_REQUESTERS - 1);
    end else begin
      last_nxt = SLOT_W'(cfg_r - CFG_W'(1));
    end
  end

  assign in_range = (CFG_W'(who_r) <= CFG_W'(last_r));
  assign is_self  = (IDX_W'(k_r) == who_r);

  // decide the command from the scan results
  always_comb begin
    status = ST_OK;
    issued = '0;
    new_tw = own_r;
    if (!in_range) begin
      status = ST_BAD_INDEX;
    end else if (cmd_r == CMD_ENTER) begin
      if (own_r != '0) begin
        status = ST_DOUBLE_ENT;
      end else if (top_r == TICKET_MAX) begin
        status = ST_SATURATED;
      end else begin
        issued = top_r + TICKET_W'(1);
        new_tw = issued;
      end
    end else begin
      if (own_r == '0) begin
        status = ST_NO_TICKET;
      end else begin
        new_tw = '0;
      end
    end
    // merge the requester's own new ticket with the best of the others
    take_w = in_range && (new_tw != '0) &&
             (!found_r || (new_tw < best_t_r) ||
              ((new_tw == best_t_r) && (who_r < IDX_W'(best_idx_r))));
  end

  // write the ticket when the decide step completes
  always_comb begin
    wr.en   = (state_r == S_DONE) && out_free && in_range && (status == ST_OK);
    wr.addr = SLOT_W'(who_r);
    wr.data = new_tw;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_SCAN;
      S_SCAN: if (k_r == last_r) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) cfg_r <= cfg_data;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // latch the command, then advance the scan one slot per cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= in_data.cmd;
      who_r   <= in_data.requester;
      last_r  <= last_nxt;
      k_r     <= '0;
      top_r   <= '0;
      own_r   <= '0;
      found_r <= 1'b0;
    end else if (state_r == S_SCAN) begin
      if (rd_data > top_r) top_r <= rd_data;
      if (is_self) begin
        own_r <= rd_data;
      end else if (rd_data != '0 && (!found_r || rd_data < best_t_r)) begin
        found_r    <= 1'b1;
        best_t_r   <= rd_data;
        best_idx_r <= k_r;
      end
      if (k_r != last_r) k_r <= k_r + SLOT_W'(1);
    end
  end

  // load the result register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_r.holder        <= take_w ? who_r : (found_r ? IDX_W'(best_idx_r) : '0);
      out_r.holder_valid  <= take_w || found_r;
      out_r.issued_ticket <= issued;
      out_r.status        <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_SCAN)
    else $error("accepted command did not start the scan");

  a_scan_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> k_r <= last_r)
    else $error("scan index ran past the slot count");

  a_no_holder_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.holder_valid |-> out_data.holder == '0)
    else $error("holder field nonzero without a holder");

  a_error_no_ticket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.issued_ticket == '0)
    else $error("ticket issued on an error status");

  a_write_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> out_valid_r)
    else $error("ticket written without a result");
`endif

endmodule
